/* hw/rtl/dss_pkg.sv */
// Shared types and constants for the data stack block.
// Used by dss_ctrl, dss_dpath and data_stack_with_stack_ops; no dependencies.
package dss_pkg;

  localparam int FUNC_W   = 3;
  localparam int IN_VAL_W = 32;
  localparam int OFF_W    = 8;
  localparam int OUT_VAL_W = 32;
  localparam int STAT_W   = 2;
  localparam int OUT_CNT_W = 9;

  localparam int SWAP_MIN = 2;
  localparam int ROT_MIN  = 3;

  localparam logic [FUNC_W-1:0] OP_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] OP_POP  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_DUP  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_SWAP = 3'd3;
  localparam logic [FUNC_W-1:0] OP_ROT  = 3'd4;
  localparam logic [FUNC_W-1:0] OP_PEEK = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

  localparam logic [2:0] ADR_CNT  = 3'd0;
  localparam logic [2:0] ADR_TOP1 = 3'd1;
  localparam logic [2:0] ADR_TOP2 = 3'd2;
  localparam logic [2:0] ADR_TOP3 = 3'd3;
  localparam logic [2:0] ADR_PEEK = 3'd4;

  localparam logic [1:0] SRC_VAL   = 2'd0;
  localparam logic [1:0] SRC_RDATA = 2'd1;
  localparam logic [1:0] SRC_A     = 2'd2;
  localparam logic [1:0] SRC_B     = 2'd3;

  typedef struct packed {
    logic       latch;
    logic [2:0] addr_sel;
    logic       wr_en;
    logic [1:0] wr_src;
    logic       cap_a;
    logic       cap_b;
    logic       fin;
  } dss_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              err;
  } dss_stat_t;

endpackage

/* hw/rtl/dss_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/dss_ctrl.sv */
// Sequencer for the data stack: steps each operation through its store accesses.
// Depends on dss_pkg.
module dss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dss_pkg::dss_stat_t   stat,
  output dss_pkg::dss_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_R1   = 3'd2;
  localparam logic [2:0] S_R2   = 3'd3;
  localparam logic [2:0] S_R3   = 3'd4;
  localparam logic [2:0] S_W1   = 3'd5;
  localparam logic [2:0] S_W2   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.addr_sel = dss_pkg::ADR_CNT;
    cmd.wr_src   = dss_pkg::SRC_VAL;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.err) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          case (stat.op) inside
            dss_pkg::OP_PUSH: begin
              cmd.wr_en = 1'b1;
              cmd.fin   = 1'b1;
              state_nxt = S_IDLE;
            end
            dss_pkg::OP_PEEK: begin
              cmd.addr_sel = dss_pkg::ADR_PEEK;
              state_nxt    = S_R1;
            end
            dss_pkg::OP_POP, dss_pkg::OP_DUP, dss_pkg::OP_SWAP, dss_pkg::OP_ROT: begin
              cmd.addr_sel = dss_pkg::ADR_TOP1;
              state_nxt    = S_R1;
            end
            default: begin
              cmd.fin   = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_R1: begin
        cmd.cap_a = 1'b1;
        case (stat.op) inside
          dss_pkg::OP_DUP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = dss_pkg::SRC_RDATA;
            cmd.fin    = 1'b1;
            state_nxt  = S_IDLE;
          end
          dss_pkg::OP_SWAP, dss_pkg::OP_ROT: begin
            cmd.addr_sel = dss_pkg::ADR_TOP2;
            state_nxt    = S_R2;
          end
          default: begin
            cmd.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_R2: begin
        cmd.cap_b = 1'b1;
        if (stat.op == dss_pkg::OP_ROT) begin
          cmd.addr_sel = dss_pkg::ADR_TOP3;
          state_nxt    = S_R3;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.addr_sel = dss_pkg::ADR_TOP1;
          cmd.wr_src   = dss_pkg::SRC_RDATA;
          state_nxt    = S_W1;
        end
      end
      S_R3: begin
        cmd.wr_en    = 1'b1;
        cmd.addr_sel = dss_pkg::ADR_TOP1;
        cmd.wr_src   = dss_pkg::SRC_RDATA;
        state_nxt    = S_W1;
      end
      S_W1: begin
        cmd.wr_en    = 1'b1;
        cmd.addr_sel = dss_pkg::ADR_TOP2;
        cmd.wr_src   = dss_pkg::SRC_A;
        if (stat.op == dss_pkg::OP_ROT) begin
          state_nxt = S_W2;
        end else begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_W2: begin
        cmd.wr_en    = 1'b1;
        cmd.addr_sel = dss_pkg::ADR_TOP3;
        cmd.wr_src   = dss_pkg::SRC_B;
        cmd.fin      = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/dss_dpath.sv */
// Datapath for the data stack: item registers, fill count, store, checks and result beat.
// Depends on dss_pkg and dss_ram.
module dss_dpath #(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dss_pkg::dss_cmd_t                   cmd,
  output dss_pkg::dss_stat_t                  stat,
  input  logic [dss_pkg::FUNC_W-1:0]          in_func,
  input  logic [dss_pkg::IN_VAL_W-1:0]        in_push_value,
  input  logic [dss_pkg::OFF_W-1:0]           in_peek_offset,
  output logic                                out_valid,
  output logic [dss_pkg::OUT_VAL_W-1:0]       out_read_value,
  output logic [dss_pkg::STAT_W-1:0]          out_status,
  output logic [dss_pkg::OUT_CNT_W-1:0]       out_entry_count
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = CW + dss_pkg::OFF_W;

  logic [dss_pkg::FUNC_W-1:0]    op_r;
  logic [VALUE_WIDTH-1:0]        val_r;
  logic [dss_pkg::OFF_W-1:0]     off_r;
  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic [VALUE_WIDTH-1:0]        a_r;
  logic [VALUE_WIDTH-1:0]        b_r;
  logic                          out_valid_r;
  logic [dss_pkg::OUT_VAL_W-1:0] out_val_r;
  logic [dss_pkg::STAT_W-1:0]    out_st_r;
  logic [CW-1:0]                 out_cnt_r;

  logic [VALUE_WIDTH+dss_pkg::IN_VAL_W-1:0] push_ext;
  logic [VALUE_WIDTH+dss_pkg::OUT_VAL_W-1:0] rd_ext;
  logic [CW+dss_pkg::OUT_CNT_W-1:0]          cnt_ext;
  logic [XW-1:0]                 cnt_x;
  logic [XW-1:0]                 off_x;
  logic [XW-1:0]                 peek_x;
  logic [CW-1:0]                 top1;
  logic [CW-1:0]                 top2;
  logic [CW-1:0]                 top3;
  logic                          full;
  logic [dss_pkg::STAT_W-1:0]    st_code;
  logic [AW-1:0]                 addr;
  logic [VALUE_WIDTH-1:0]        wdata;
  logic [VALUE_WIDTH-1:0]        rdata;

  assign push_ext = {{VALUE_WIDTH{1'b0}}, in_push_value};
  assign rd_ext   = {{dss_pkg::OUT_VAL_W{1'b0}}, rdata};
  assign cnt_x    = {{dss_pkg::OFF_W{1'b0}}, count_r};
  assign off_x    = {{CW{1'b0}}, off_r};
  assign peek_x   = cnt_x - off_x - XW'(1);
  assign top1     = count_r - CW'(1);
  assign top2     = count_r - CW'(dss_pkg::SWAP_MIN);
  assign top3     = count_r - CW'(dss_pkg::ROT_MIN);
  assign full     = (count_r == CW'(STACK_DEPTH));

  always_comb begin
    st_code = dss_pkg::ST_OK;
    unique case (op_r)
      dss_pkg::OP_PUSH: if (full) st_code = dss_pkg::ST_OVER;
      dss_pkg::OP_POP:  if (count_r == '0) st_code = dss_pkg::ST_UNDER;
      dss_pkg::OP_DUP: begin
        if (count_r == '0) begin
          st_code = dss_pkg::ST_UNDER;
        end else if (full) begin
          st_code = dss_pkg::ST_OVER;
        end
      end
      dss_pkg::OP_SWAP: if (count_r < CW'(dss_pkg::SWAP_MIN)) st_code = dss_pkg::ST_UNDER;
      dss_pkg::OP_ROT:  if (count_r < CW'(dss_pkg::ROT_MIN)) st_code = dss_pkg::ST_UNDER;
      dss_pkg::OP_PEEK: if (off_x >= cnt_x) st_code = dss_pkg::ST_UNDER;
      default: st_code = dss_pkg::ST_OK;
    endcase
  end

  assign stat.op  = op_r;
  assign stat.err = (st_code != dss_pkg::ST_OK);

  always_comb begin
    unique case (cmd.addr_sel)
      dss_pkg::ADR_TOP1: addr = top1[AW-1:0];
      dss_pkg::ADR_TOP2: addr = top2[AW-1:0];
      dss_pkg::ADR_TOP3: addr = top3[AW-1:0];
      dss_pkg::ADR_PEEK: addr = peek_x[AW-1:0];
      default:           addr = count_r[AW-1:0];
    endcase
  end

  always_comb begin
    unique case (cmd.wr_src)
      dss_pkg::SRC_RDATA: wdata = rdata;
      dss_pkg::SRC_A:     wdata = a_r;
      dss_pkg::SRC_B:     wdata = b_r;
      default:            wdata = val_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (st_code == dss_pkg::ST_OK) begin
      case (op_r) inside
        dss_pkg::OP_PUSH, dss_pkg::OP_DUP: count_nxt = count_r + CW'(1);
        dss_pkg::OP_POP:                   count_nxt = count_r - CW'(1);
        default:                           count_nxt = count_r;
      endcase
    end
  end

  dss_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cmd.fin) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_func;
      val_r <= push_ext[VALUE_WIDTH-1:0];
      off_r <= in_peek_offset;
    end
    if (cmd.cap_a) begin
      a_r <= rdata;
    end
    if (cmd.cap_b) begin
      b_r <= rdata;
    end
    if (cmd.fin) begin
      out_st_r  <= st_code;
      out_cnt_r <= count_nxt;
      if ((st_code == dss_pkg::ST_OK) &&
          ((op_r == dss_pkg::OP_POP) || (op_r == dss_pkg::OP_PEEK))) begin
        out_val_r <= rd_ext[dss_pkg::OUT_VAL_W-1:0];
      end else begin
        out_val_r <= '0;
      end
    end
  end

  assign cnt_ext         = {{dss_pkg::OUT_CNT_W{1'b0}}, out_cnt_r};
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_status      = out_st_r;
  assign out_entry_count = cnt_ext[dss_pkg::OUT_CNT_W-1:0];

endmodule

/* hw/rtl/data_stack_with_stack_ops.sv */
// Top level of the bounded LIFO data stack with push, pop, dup, swap, rot and peek.
// Depends on dss_pkg, dss_ctrl and dss_dpath (which holds dss_ram).
//
// One operation is taken when start is high and busy is low; its single result
// beat appears on the out_ ports with out_valid high for exactly one cycle and
// cannot be held off by the receiver. All entries live in one single-port RAM,
// so an operation does its store accesses one at a time from dispatch on: push writes
// once, pop and peek read once, dup reads and writes once, swap does two of each, rot
// three, a failed operation or unused code none. The result beat is shown in the cycle
// in which busy drops, so the next operation can be accepted while it is shown.
module data_stack_with_stack_ops #(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dss_pkg::FUNC_W-1:0]    in_func,
  input  logic [dss_pkg::IN_VAL_W-1:0]  in_push_value,
  input  logic [dss_pkg::OFF_W-1:0]     in_peek_offset,
  output logic                          out_valid,
  output logic [dss_pkg::OUT_VAL_W-1:0] out_read_value,
  output logic [dss_pkg::STAT_W-1:0]    out_status,
  output logic [dss_pkg::OUT_CNT_W-1:0] out_entry_count
);

  dss_pkg::dss_cmd_t  cmd;
  dss_pkg::dss_stat_t stat;

  dss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dss_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_push_value   (in_push_value),
    .in_peek_offset  (in_peek_offset),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule

/* verif/data_stack_with_stack_ops_tb.sv */
// Self-checking testbench for data_stack_with_stack_ops: directed corner ops, then
// random traffic over all codes that fills the stack to overflow and drains it to underflow.
// Depends on dss_pkg and the data_stack_with_stack_ops RTL.
module data_stack_with_stack_ops_tb;

  localparam int STACK_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [dss_pkg::FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [dss_pkg::FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  typedef struct packed {
    logic [dss_pkg::OUT_VAL_W-1:0] read_value;
    logic [dss_pkg::STAT_W-1:0]    status;
    logic [dss_pkg::OUT_CNT_W-1:0] entry_count;
  } stack_result_t;

  typedef struct packed {
    logic [dss_pkg::FUNC_W-1:0]    func;
    logic [dss_pkg::IN_VAL_W-1:0]  value;
    logic [dss_pkg::OFF_W-1:0]     offset;
    logic                          typed;
    logic [dss_pkg::OUT_VAL_W-1:0] want_value;
    logic [dss_pkg::STAT_W-1:0]    want_status;
    logic [dss_pkg::OUT_CNT_W-1:0] want_count;
  } directed_op_t;

  typedef enum {MIX_MODE, CLIMB_MODE, DESCEND_MODE} traffic_mode_t;

  localparam int NUM_DIRECTED = 25;
  localparam directed_op_t DIRECTED_OPS [NUM_DIRECTED] = '{
    '{dss_pkg::OP_POP,  32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{dss_pkg::OP_DUP,  32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{dss_pkg::OP_SWAP, 32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{dss_pkg::OP_ROT,  32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'hff, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd0},
    '{FUNC_SPARE6,      32'hffff_ffff, 8'hff, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{FUNC_SPARE7,      32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_PUSH, 32'hffff_ffff, 8'h00, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd1},
    '{dss_pkg::OP_SWAP, 32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd1},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h00, 1'b1, 32'hffff_ffff, dss_pkg::ST_OK,    9'd1},
    '{dss_pkg::OP_PUSH, 32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd2},
    '{dss_pkg::OP_ROT,  32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd2},
    '{dss_pkg::OP_SWAP, 32'h0,         8'h00, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd2},
    '{dss_pkg::OP_PUSH, 32'h8000_0001, 8'h00, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd3},
    '{dss_pkg::OP_ROT,  32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h01, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h02, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_PEEK, 32'h0,         8'h03, 1'b1, 32'h0,         dss_pkg::ST_UNDER, 9'd3},
    '{dss_pkg::OP_DUP,  32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_POP,  32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{dss_pkg::OP_POP,  32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0},
    '{FUNC_SPARE7,      32'h5a5a_a5a5, 8'h80, 1'b1, 32'h0,         dss_pkg::ST_OK,    9'd2},
    '{dss_pkg::OP_POP,  32'h0,         8'h00, 1'b0, 32'h0,         dss_pkg::ST_OK,    9'd0}
  };

  localparam logic [dss_pkg::FUNC_W-1:0] OP_BY_SLOT [7] = '{
    dss_pkg::OP_PUSH, dss_pkg::OP_POP, dss_pkg::OP_DUP, dss_pkg::OP_SWAP,
    dss_pkg::OP_ROT, dss_pkg::OP_PEEK, FUNC_SPARE6
  };

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [dss_pkg::FUNC_W-1:0]    in_func;
  logic [dss_pkg::IN_VAL_W-1:0]  in_push_value;
  logic [dss_pkg::OFF_W-1:0]     in_peek_offset;
  logic                          out_valid;
  logic [dss_pkg::OUT_VAL_W-1:0] out_read_value;
  logic [dss_pkg::STAT_W-1:0]    out_status;
  logic [dss_pkg::OUT_CNT_W-1:0] out_entry_count;

  logic [VALUE_WIDTH-1:0] shadow_store [STACK_DEPTH];
  int                     shadow_fill;
  stack_result_t          pending_results [$];
  int                     error_count = 0;
  int                     cycle_count = 0;
  int                     burst_left  = 1;

  data_stack_with_stack_ops #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_push_value  (in_push_value),
    .in_peek_offset (in_peek_offset),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic stack_result_t apply_stack_op(input logic [dss_pkg::FUNC_W-1:0] op,
                                                   input logic [dss_pkg::IN_VAL_W-1:0] val,
                                                   input logic [dss_pkg::OFF_W-1:0] off);
    stack_result_t          res;
    logic [VALUE_WIDTH-1:0] top_a;
    logic [VALUE_WIDTH-1:0] top_b;
    logic [VALUE_WIDTH-1:0] top_c;
    int                     n;
    res.read_value = '0;
    res.status     = dss_pkg::ST_OK;
    n = shadow_fill;
    case (op)
      dss_pkg::OP_PUSH: begin
        if (n >= STACK_DEPTH) res.status = dss_pkg::ST_OVER;
        else begin
          shadow_store[n] = val[VALUE_WIDTH-1:0];
          shadow_fill = n + 1;
        end
      end
      dss_pkg::OP_POP: begin
        if (n == 0) res.status = dss_pkg::ST_UNDER;
        else begin
          res.read_value = shadow_store[n-1];
          shadow_fill = n - 1;
        end
      end
      dss_pkg::OP_DUP: begin
        if (n == 0) res.status = dss_pkg::ST_UNDER;
        else if (n >= STACK_DEPTH) res.status = dss_pkg::ST_OVER;
        else begin
          shadow_store[n] = shadow_store[n-1];
          shadow_fill = n + 1;
        end
      end
      dss_pkg::OP_SWAP: begin
        if (n < dss_pkg::SWAP_MIN) res.status = dss_pkg::ST_UNDER;
        else begin
          top_a = shadow_store[n-1];
          shadow_store[n-1] = shadow_store[n-2];
          shadow_store[n-2] = top_a;
        end
      end
      dss_pkg::OP_ROT: begin
        if (n < dss_pkg::ROT_MIN) res.status = dss_pkg::ST_UNDER;
        else begin
          top_a = shadow_store[n-1];
          top_b = shadow_store[n-2];
          top_c = shadow_store[n-3];
          shadow_store[n-1] = top_c;
          shadow_store[n-2] = top_a;
          shadow_store[n-3] = top_b;
        end
      end
      dss_pkg::OP_PEEK: begin
        if (int'(off) >= n) res.status = dss_pkg::ST_UNDER;
        else res.read_value = shadow_store[n-1-int'(off)];
      end
      default: begin
      end
    endcase
    res.entry_count = shadow_fill[dss_pkg::OUT_CNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic drive_beat(input logic [dss_pkg::FUNC_W-1:0] f,
                            input logic [dss_pkg::IN_VAL_W-1:0] v,
                            input logic [dss_pkg::OFF_W-1:0] o, input logic typed,
                            input stack_result_t typed_res);
    stack_result_t predicted;
    int            gap;
    @(negedge clk);
    start          = 1'b1;
    in_func        = f;
    in_push_value  = v;
    in_peek_offset = o;
    do @(posedge clk); while (busy);
    predicted = apply_stack_op(f, v, o);
    pending_results.push_back(typed ? typed_res : predicted);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic send_random(input traffic_mode_t mode);
    int unsigned                  thresh [7];
    int unsigned                  roll;
    int                           slot;
    logic [dss_pkg::FUNC_W-1:0]   f;
    logic [dss_pkg::IN_VAL_W-1:0] v;
    logic [dss_pkg::OFF_W-1:0]    o;
    case (mode)
      MIX_MODE:     thresh = '{30, 50, 60, 70, 80, 95, 100};
      CLIMB_MODE:   thresh = '{88, 89, 95, 96, 97, 99, 100};
      default:      thresh = '{1, 95, 96, 97, 98, 99, 100};
    endcase
    roll = $urandom_range(0, 99);
    slot = 6;
    for (int i = 6; i >= 0; i--) if (roll < thresh[i]) slot = i;
    f = OP_BY_SLOT[slot];
    if (f == FUNC_SPARE6 && $urandom_range(0, 1) == 1) f = FUNC_SPARE7;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) o = dss_pkg::OFF_W'($urandom_range(0, 255));
    else o = dss_pkg::OFF_W'($urandom_range(0, (shadow_fill > 255) ? 255 : shadow_fill));
    drive_beat(f, v, o, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, read_value", out_read_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.read_value)
          report_mismatch("read_value", out_read_value, want.read_value);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(out_entry_count), 32'(want.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d beats outstanding", cycle_count,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int            extra;
    stack_result_t typed_res;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_func        = dss_pkg::OP_PUSH;
    in_push_value  = '0;
    in_peek_offset = '0;
    shadow_fill    = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_OPS[i]) begin
      typed_res.read_value  = DIRECTED_OPS[i].want_value;
      typed_res.status      = DIRECTED_OPS[i].want_status;
      typed_res.entry_count = DIRECTED_OPS[i].want_count;
      drive_beat(DIRECTED_OPS[i].func, DIRECTED_OPS[i].value, DIRECTED_OPS[i].offset,
                 DIRECTED_OPS[i].typed, typed_res);
    end

    repeat (40) send_random(MIX_MODE);
    wait_drained();

    // climb to full and keep hitting overflow, then drain into underflow
    extra = 0;
    while (extra < 10) begin
      send_random(CLIMB_MODE);
      if (shadow_fill == STACK_DEPTH) extra++;
    end
    extra = 0;
    while (extra < 10) begin
      send_random(DESCEND_MODE);
      if (shadow_fill == 0) extra++;
    end
    repeat (20) send_random(MIX_MODE);

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
